@@ rtl/core/mcd_pkg.sv @@
`timescale 1ns / 1ps

package mcd_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int BYTE_W      = 8;

	localparam logic [BYTE_W-1:0] MARK_START = 8'h5E;
	localparam logic [BYTE_W-1:0] MARK_END   = 8'h24;

	// controller -> datapath
	typedef struct packed {
		logic fill_clr;   // empty the store
		logic fill_wr;    // append the incoming byte
		logic rd_first;   // read entry 0, start of drain
		logic rd_next;    // read the following entry
		logic out_load;   // load the output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_start;
		logic is_end;
		logic fill_nz;
		logic fill_at_last;  // next stored byte fills the store
		logic idx_last;      // read index is on the last stored byte
		logic out_free;
	} sts_t;

endpackage

@@ rtl/core/mcd_rx_if.sv @@
`timescale 1ns / 1ps

interface mcd_rx_if;
	logic                        valid;
	logic                        ready;
	logic [mcd_pkg::BYTE_W-1:0]  rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/core/mcd_code_if.sv @@
`timescale 1ns / 1ps

interface mcd_code_if;
	logic                        valid;
	logic                        ready;
	logic [mcd_pkg::BYTE_W-1:0]  code_byte;
	logic                        code_last;

	modport source (output valid, output code_byte, output code_last, input ready);
	modport sink (input valid, input code_byte, input code_last, output ready);
endinterface

@@ rtl/core/marker_delimited_code_deframer_unit.sv @@
`timescale 1ns / 1ps

// Frame extractor for a byte stream: 0x5E opens (or restarts) a frame, 0x24 closes it and
// the bytes in between come out in order, the last one flagged. Frames that reach 64 bytes
// are dropped; bytes outside a frame are ignored. Outside a drain, one byte is accepted
// every cycle. A closing marker on a non-empty frame holds rx.ready low while its bytes
// drain: the first read of the store RAM's registered read port is issued in the marker's
// own transfer cycle, then one byte per cycle while the output register is free.
// Stalls on the output lengthen the drain. The final byte may still sit in the output
// register while new input is taken. The store needs no clearing after reset.
module marker_delimited_code_deframer_unit (
	input  logic       clk,
	input  logic       arst_n,
	mcd_rx_if.sink     rx,
	mcd_code_if.source code
);
	import mcd_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic rx_ready;

	mcd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx_valid(rx.valid),
		.rx_ready(rx_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	mcd_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rx_byte   (rx.rx_byte),
		.code_ready(code.ready),
		.code_valid(code.valid),
		.code_byte (code.code_byte),
		.code_last (code.code_last),
		.sts       (sts)
	);

	assign rx.ready = rx_ready;

	// output register is never overwritten before its transfer
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!code.valid || code.ready))
		else $error("output register overwritten");

	// results are only produced while input is held off
	a_load_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !rx.ready)
		else $error("output load outside drain");

	// a stored byte leaves the fill count nonzero
	a_fill_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fill_wr && !cmd.fill_clr) |=> sts.fill_nz)
		else $error("fill count lost a write");

	// a drain starts only on a closing marker
	a_drain_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_first |-> (rx.valid && sts.is_end && sts.fill_nz))
		else $error("drain without end marker");
endmodule

@@ rtl/core/mcd_ram.sv @@
`timescale 1ns / 1ps

module mcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

@@ rtl/core/mcd_dpath.sv @@
`timescale 1ns / 1ps

module mcd_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mcd_pkg::cmd_t              cmd,
	input  logic [mcd_pkg::BYTE_W-1:0] rx_byte,
	input  logic                       code_ready,
	output logic                       code_valid,
	output logic [mcd_pkg::BYTE_W-1:0] code_byte,
	output logic                       code_last,
	output mcd_pkg::sts_t              sts
);
	import mcd_pkg::*;

	logic [CNT_W-1:0]  fill_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] rd_addr;
	logic [BYTE_W-1:0] rd_data;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	assign rd_addr = cmd.rd_first ? '0 : (cmd.rd_next ? idx_q + 1'b1 : idx_q);

	mcd_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.fill_wr),
		.waddr(fill_q[ADDR_W-1:0]),
		.wdata(rx_byte),
		.re   (cmd.rd_first | cmd.rd_next),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.fill_clr) begin
				fill_q <= '0;
			end else if (cmd.fill_wr) begin
				fill_q <= fill_q + 1'b1;
			end
			if (cmd.rd_first) begin
				idx_q <= '0;
			end else if (cmd.rd_next) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (code_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_byte_q <= rd_data;
			out_last_q <= sts.idx_last;
		end
	end

	assign sts.is_start     = (rx_byte == MARK_START);
	assign sts.is_end       = (rx_byte == MARK_END);
	assign sts.fill_nz      = (fill_q != '0);
	assign sts.fill_at_last = (fill_q == CNT_W'(STORE_DEPTH - 1));
	assign sts.idx_last     = ({1'b0, idx_q} + 1'b1 == fill_q);
	assign sts.out_free     = !out_valid_q || code_ready;

	assign code_valid = out_valid_q;
	assign code_byte  = out_byte_q;
	assign code_last  = out_last_q;
endmodule

@@ rtl/core/mcd_ctrl.sv @@
`timescale 1ns / 1ps

module mcd_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rx_valid,
	output logic          rx_ready,
	input  mcd_pkg::sts_t sts,
	output mcd_pkg::cmd_t cmd
);
	import mcd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FRAME,
		ST_DRAIN
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   acc;

	assign rx_ready = (state_q != ST_DRAIN);
	assign acc      = rx_valid && rx_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && sts.is_start) begin
					cmd.fill_clr = 1'b1;
					state_d      = ST_FRAME;
				end
			end
			ST_FRAME: begin
				if (acc) begin
					priority if (sts.is_start) begin
						cmd.fill_clr = 1'b1;
					end else if (sts.is_end) begin
						if (sts.fill_nz) begin
							cmd.rd_first = 1'b1;
							state_d      = ST_DRAIN;
						end else begin
							cmd.fill_clr = 1'b1;
							state_d      = ST_IDLE;
						end
					end else begin
						cmd.fill_wr = 1'b1;
						// store full: drop the frame
						if (sts.fill_at_last) begin
							cmd.fill_clr = 1'b1;
							state_d      = ST_IDLE;
						end
					end
				end
			end
			ST_DRAIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					if (sts.idx_last) begin
						cmd.fill_clr = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						cmd.rd_next = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
	import mcd_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int DIR_LEN     = 23;
	localparam int ITEM_TARGET = 130;
	localparam int DRAIN_TAIL  = 16;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              last;
	} code_rec_t;

	// typed rows carry either no code or a single one-byte code
	typedef struct {
		logic [BYTE_W-1:0] rx;
		bit                typed;
		bit                one_code;
		logic [BYTE_W-1:0] code;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	mcd_rx_if   rx_if ();
	mcd_code_if code_if ();

	marker_delimited_code_deframer_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.code   (code_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// frame tracking state
	bit                frame_open;
	int unsigned       frame_fill;
	logic [BYTE_W-1:0] frame_store [STORE_DEPTH];

	code_rec_t step_codes [$];
	code_rec_t code_expected [$];
	int        err_cnt;
	int        cycle_cnt;
	int        sent_cnt;
	bit        steady;

	dir_row_t dir_rows [DIR_LEN] = '{
		'{MARK_END,   1, 0, 8'h00},  // close with no open frame
		'{8'h00,      1, 0, 8'h00},  // outside a frame
		'{8'hFF,      1, 0, 8'h00},
		'{MARK_START, 1, 0, 8'h00},
		'{MARK_END,   1, 0, 8'h00},  // empty frame
		'{MARK_START, 1, 0, 8'h00},
		'{8'h00,      1, 0, 8'h00},
		'{MARK_END,   1, 1, 8'h00},
		'{MARK_START, 1, 0, 8'h00},
		'{8'hFF,      1, 0, 8'h00},
		'{MARK_END,   1, 1, 8'hFF},
		'{MARK_START, 0, 0, 8'h00},
		'{8'hA5,      0, 0, 8'h00},
		'{MARK_START, 1, 0, 8'h00},  // restart drops A5
		'{8'h3C,      0, 0, 8'h00},
		'{8'hC3,      0, 0, 8'h00},
		'{MARK_END,   0, 0, 8'h00},
		'{8'h5A,      1, 0, 8'h00},
		'{MARK_END,   1, 0, 8'h00},
		'{MARK_START, 0, 0, 8'h00},
		'{MARK_START, 0, 0, 8'h00},
		'{8'h81,      0, 0, 8'h00},
		'{MARK_END,   0, 0, 8'h00}
	};

	// codes released by one received byte go to step_codes
	function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
		step_codes.delete();
		if (b == MARK_START) begin
			frame_open = 1'b1;
			frame_fill = 0;
		end else if (b == MARK_END) begin
			if (frame_open && frame_fill > 0) begin
				for (int k = 0; k < frame_fill; k++)
					step_codes.push_back('{frame_store[k], k == frame_fill - 1});
			end
			frame_open = 1'b0;
			frame_fill = 0;
		end else if (frame_open) begin
			frame_store[frame_fill] = b;
			frame_fill++;
			// store full: frame dropped
			if (frame_fill >= STORE_DEPTH) begin
				frame_open = 1'b0;
				frame_fill = 0;
			end
		end
	endfunction

	function automatic logic [BYTE_W-1:0] plain_byte();
		logic [BYTE_W-1:0] v;
		v = BYTE_W'($urandom_range(255));
		while (v == MARK_START || v == MARK_END)
			v = BYTE_W'($urandom_range(255));
		return v;
	endfunction

	// returns at the edge of the transfer, valid left high
	task automatic put_byte(input logic [BYTE_W-1:0] b);
		while (!steady && $urandom_range(99) < 32) begin
			rx_if.valid <= 1'b0;
			@(posedge clk);
		end
		rx_if.valid   <= 1'b1;
		rx_if.rx_byte <= b;
		@(posedge clk);
		while (!rx_if.ready)
			@(posedge clk);
		sent_cnt++;
		deframe_byte(b);
	endtask

	task automatic send_predicted(input logic [BYTE_W-1:0] b);
		put_byte(b);
		foreach (step_codes[i])
			code_expected.push_back(step_codes[i]);
	endtask

	always @(posedge clk) begin
		code_rec_t got, want;
		if (arst_n && code_if.valid && code_if.ready) begin
			got = '{code_if.code_byte, code_if.code_last};
			if (code_expected.size() == 0) begin
				$display("%0t: unexpected code transfer: byte %02h last %0b",
					$time, got.data, got.last);
				err_cnt++;
			end else begin
				want = code_expected.pop_front();
				if (got.data !== want.data) begin
					$display("%0t: code_byte mismatch: expected %02h, actual %02h",
						$time, want.data, got.data);
					err_cnt++;
				end
				if (got.last !== want.last) begin
					$display("%0t: code_last mismatch: expected %0b, actual %0b",
						$time, want.last, got.last);
					err_cnt++;
				end
			end
		end
		code_if.ready <= steady || ($urandom_range(99) >= 32);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("marker_delimited_code_deframer_unit regression: fail");
			$finish;
		end
	end

	initial begin
		int seq_idx;
		int len;
		int r;
		arst_n        = 1'b0;
		rx_if.valid   = 1'b0;
		rx_if.rx_byte = '0;
		code_if.ready = 1'b0;
		err_cnt       = 0;
		cycle_cnt     = 0;
		sent_cnt      = 0;
		steady        = 1'b0;
		frame_open    = 1'b0;
		frame_fill    = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			put_byte(dir_rows[i].rx);
			if (!dir_rows[i].typed) begin
				foreach (step_codes[j])
					code_expected.push_back(step_codes[j]);
			end else if (dir_rows[i].one_code) begin
				code_expected.push_back('{dir_rows[i].code, 1'b1});
			end
		end

		seq_idx = 0;
		while (sent_cnt < ITEM_TARGET || seq_idx <= 3) begin
			// the longest frame runs with no idling on either side
			steady = (seq_idx == 1);
			if (seq_idx == 1) begin
				// longest frame that still drains
				send_predicted(MARK_START);
				repeat (STORE_DEPTH - 1) send_predicted(plain_byte());
				send_predicted(MARK_END);
			end else if (seq_idx == 3) begin
				// fills the store; the close is ignored
				send_predicted(MARK_START);
				repeat (STORE_DEPTH) send_predicted(plain_byte());
				send_predicted(MARK_END);
			end else begin
				r = $urandom_range(99);
				if (r < 70) begin
					len = $urandom_range(1, 8);
					send_predicted(MARK_START);
					repeat (len) send_predicted(plain_byte());
					send_predicted(MARK_END);
				end else if (r < 85) begin
					len = $urandom_range(0, 4);
					send_predicted(MARK_START);
					repeat (len) send_predicted(plain_byte());
					if ($urandom_range(1)) begin
						send_predicted(MARK_START);
						len = $urandom_range(0, 3);
						repeat (len) send_predicted(plain_byte());
						send_predicted(MARK_END);
					end
				end else begin
					len = $urandom_range(1, 4);
					repeat (len) begin
						case ($urandom_range(3))
							0: send_predicted(MARK_START);
							1: send_predicted(MARK_END);
							default: send_predicted(BYTE_W'($urandom_range(255)));
						endcase
					end
				end
			end
			seq_idx++;
		end
		steady = 1'b0;
		rx_if.valid <= 1'b0;

		while (code_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);
		if (err_cnt == 0)
			$display("marker_delimited_code_deframer_unit regression: pass");
		else
			$display("marker_delimited_code_deframer_unit regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/mcd_pkg.sv
rtl/core/mcd_rx_if.sv
rtl/core/mcd_code_if.sv
rtl/core/mcd_ram.sv
rtl/core/mcd_dpath.sv
rtl/core/mcd_ctrl.sv
rtl/core/marker_delimited_code_deframer_unit.sv
sim/tb_top.sv
